// ===== rtl/core/fba_pkg.sv =====
// fba_pkg: shared types and constants for the partition allocator
// no dependencies; imported by fba_search and fit_block_allocator_unit
`timescale 1ns / 1ps

package fba_pkg;

  // default sizing of the partition table
  localparam int NUM_PARTS_DEF = 32;
  localparam int SIZE_BITS_DEF = 16;

  // fixed field widths of the ports
  localparam int IDX_W      = 5;
  localparam int REQ_W      = 16;
  localparam int MODE_W     = 2;
  localparam int BIU_W      = 6;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  // request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // fit modes; the fourth code behaves as first fit
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS   = 1'b1;

  // configuration reset values
  localparam logic [MODE_W-1:0] FIT_MODE_RST = MODE_BEST;
  localparam logic [BIU_W-1:0]  BLOCKS_RST   = 6'd32;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] part_index;
    logic [REQ_W-1:0] req_size;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] chosen_index;
    logic [REQ_W-1:0] leftover;
  } res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/fba_mem.sv =====
// fba_mem: single-port synchronous partition table, registered read
// no dependencies; sized by its parameters
`timescale 1ns / 1ps

module fba_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access a cycle: write, or registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/core/fba_search.sv =====
// fba_search: sequencer for table clearing, loads and the fit search
// depends on fba_pkg and fba_mem
`timescale 1ns / 1ps

module fba_search #(
  parameter int NUM_PARTS = fba_pkg::NUM_PARTS_DEF,
  parameter int SIZE_BITS = fba_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  fba_pkg::req_t                 request,
  input  logic [fba_pkg::MODE_W-1:0]    fit_mode,
  input  logic [fba_pkg::BIU_W-1:0]     blocks_in_use,
  output logic                          busy,
  output logic                          done,
  output fba_pkg::res_t                 result
);

  import fba_pkg::*;

  localparam int IW = $clog2(NUM_PARTS);
  localparam int CW = IW + 1;
  localparam int SW = SIZE_BITS;
  localparam int MW = SW + 1;
  localparam int XW = (IW > IDX_W) ? IW : IDX_W;
  localparam int QW = (SW > REQ_W) ? SW : REQ_W;
  localparam int LW = (CW > BIU_W) ? CW : BIU_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PARTS - 1);

  state_t state, state_next;

  // memory port
  logic          mem_en, mem_we;
  logic [IW-1:0] mem_addr;
  logic [MW-1:0] mem_wdata, mem_rdata;

  // search registers
  logic [SW-1:0] req_sz;
  logic [CW-1:0] limit;
  logic [CW-1:0] iss;
  logic [IW-1:0] cmp;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [SW-1:0] best_left;
  logic [SW-1:0] best_size;
  logic [IW-1:0] clr;

  // decoded request fields
  logic [QW-1:0]   in_size_ext;
  logic [SW-1:0]   in_size;
  logic [XW-1:0]   pidx_ext;
  logic            load_ok;
  logic [LW-1:0]   biu_ext;
  logic [CW-1:0]   lim_in;

  // entry under compare
  logic          rd_used;
  logic [SW-1:0] rd_size;
  logic          hit;
  logic [SW-1:0] left;
  logic          take;
  logic          last_cmp;
  logic          iss_more;

  assign in_size_ext = QW'(request.req_size);
  assign in_size     = in_size_ext[SW-1:0];
  assign pidx_ext    = XW'(request.part_index);
  assign load_ok     = ((XW + 1)'(request.part_index) < (XW + 1)'(NUM_PARTS));
  assign biu_ext     = LW'(blocks_in_use);
  assign lim_in      = (biu_ext > LW'(NUM_PARTS)) ? CW'(NUM_PARTS) : CW'(biu_ext);

  assign rd_used  = mem_rdata[SW];
  assign rd_size  = mem_rdata[SW-1:0];
  assign hit      = !rd_used && (rd_size >= req_sz);
  assign left     = rd_size - req_sz;
  assign take     = hit && (!found ||
                            ((fit_mode == MODE_BEST) && (left < best_left)) ||
                            ((fit_mode == MODE_WORST) && (left > best_left)));
  assign last_cmp = ((CW'(cmp) + CW'(1)) == limit);
  assign iss_more = (iss < limit);

  fba_mem #(
    .DEPTH (NUM_PARTS),
    .WIDTH (MW)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory port control
  always_comb begin
    state_next = state;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr;
        if (clr == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (request.op == OP_LOAD) begin
            if (load_ok) begin
              mem_en    = 1'b1;
              mem_we    = 1'b1;
              mem_addr  = pidx_ext[IW-1:0];
              mem_wdata = {1'b0, in_size};
            end
          end else if (lim_in == '0) begin
            state_next = ST_DONE;
          end else begin
            mem_en     = 1'b1;
            mem_addr   = '0;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (iss_more) begin
          mem_en   = 1'b1;
          mem_addr = iss[IW-1:0];
        end
        if (last_cmp) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (found) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = best_idx;
          mem_wdata = {1'b1, best_size};
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (state == ST_CLEAR) begin
      clr <= clr + IW'(1);
    end
  end

  // search datapath: one entry compared per cycle
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start && (request.op == OP_ALLOC)) begin
      req_sz    <= in_size;
      limit     <= lim_in;
      iss       <= CW'(1);
      cmp       <= '0;
      found     <= 1'b0;
      best_idx  <= '0;
      best_left <= '0;
      best_size <= '0;
    end else if (state == ST_SCAN) begin
      if (iss_more) iss <= iss + CW'(1);
      cmp <= cmp + IW'(1);
      if (take) begin
        found     <= 1'b1;
        best_idx  <= cmp;
        best_left <= left;
        best_size <= rd_size;
      end
    end
  end

  logic [XW-1:0] best_idx_ext;
  logic [QW-1:0] best_left_ext;

  assign best_idx_ext  = XW'(best_idx);
  assign best_left_ext = QW'(best_left);

  // outputs
  assign busy                = (state != ST_IDLE);
  assign done                = (state == ST_DONE);
  assign result.granted      = found;
  assign result.chosen_index = best_idx_ext[IDX_W-1:0];
  assign result.leftover     = best_left_ext[REQ_W-1:0];

  // a result strobe is never held: done drops again after each strobe
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  // a grant always marks its partition used in the same cycle
  a_grant_marks: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (mem_we && (mem_addr == best_idx) && mem_wdata[SW]))
    else $error("grant without used mark");

  // an accepted allocation request always leaves the block busy
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.op == OP_ALLOC)) |=> busy)
    else $error("allocation not started");

  // the compare index stays inside the searched range
  a_cmp_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CW'(cmp) < limit))
    else $error("compare index out of range");

  // no read is issued beyond the searched range
  a_iss_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (iss <= limit))
    else $error("read index out of range");

endmodule

// ===== rtl/core/fit_block_allocator_unit.sv =====
// fit_block_allocator_unit: fixed-partition allocator, first, best or worst fit
// Flow: a taken request searches N partitions, N being the min of blocks_in_use
//   and NUM_PARTS, then strobes done; a taken load writes an in-range table entry.
// Throughput: a new allocation waits until busy drops, the single table port reading one
//   entry a cycle; loads go one per cycle. The receiver cannot stall results.
// Reset: a clearing pass zeroes every table entry, busy stays high meanwhile.
`timescale 1ns / 1ps

module fit_block_allocator_unit #(
  parameter int NUM_PARTS = fba_pkg::NUM_PARTS_DEF,
  parameter int SIZE_BITS = fba_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  fba_pkg::req_t                   request,
  output logic                            busy,
  output logic                            done,
  output fba_pkg::res_t                   result,
  input  logic                            cfg_we,
  input  logic [fba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fba_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import fba_pkg::*;

  logic [MODE_W-1:0] fit_mode;
  logic [BIU_W-1:0]  blocks_in_use;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= FIT_MODE_RST;
      blocks_in_use <= BLOCKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT_MODE: fit_mode      <= cfg_wdata[MODE_W-1:0];
        CFG_BLOCKS:   blocks_in_use <= cfg_wdata[BIU_W-1:0];
        default:      fit_mode      <= fit_mode;
      endcase
    end
  end

  fba_search #(
    .NUM_PARTS (NUM_PARTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_search (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .request       (request),
    .fit_mode      (fit_mode),
    .blocks_in_use (blocks_in_use),
    .busy          (busy),
    .done          (done),
    .result        (result)
  );

endmodule
